FILE: rtl/core/fgk_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fgk_pkg;

    // Joint count and the width of the joint index.
    localparam int JOINTS   = 8;
    localparam int JOINT_W  = 3;

    localparam int COEF_W   = 18;
    localparam int STATE_W  = 32;

    // Configuration port.
    localparam int PADDR_W  = 5;
    localparam int PDATA_W  = 32;
    localparam int REG_IDX_W = 3;
    localparam int REG_COUNT = 6;

    localparam logic [REG_IDX_W-1:0] REG_A_POS_POS = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_A_POS_VEL = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_A_VEL_POS = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_A_VEL_VEL = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_POS  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_VEL  = 3'd5;

    // Item kinds.
    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_PRESET = 1'b1;

    // Reset values of the coefficients, Q3.14.
    localparam logic signed [COEF_W-1:0] COEF_ONE  = 18'sd16384;
    localparam logic signed [COEF_W-1:0] COEF_ZERO = 18'sd0;

    typedef logic signed [COEF_W-1:0]  coef_t;
    typedef logic signed [STATE_W-1:0] state_t;
    typedef logic [JOINT_W-1:0]        joint_t;

    typedef struct packed {
        coef_t a_pos_pos;
        coef_t a_pos_vel;
        coef_t a_vel_pos;
        coef_t a_vel_vel;
        coef_t gain_pos;
        coef_t gain_vel;
    } coef_set_t;

endpackage

`default_nettype wire

FILE: rtl/core/fgk_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module fgk_cfg
    import fgk_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [PADDR_W-1:0]   paddr,
    input  wire logic [PDATA_W-1:0]   pwdata,
    output logic      [PDATA_W-1:0]   prdata,
    output logic                      pready,
    output coef_set_t                 coefs
);

    coef_set_t              coefs_reg;
    logic [REG_IDX_W-1:0]   reg_idx;
    logic                   wr_en;
    coef_t                  wr_val;
    coef_t                  rd_val;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign wr_val  = coef_t'(pwdata[COEF_W-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coefs_reg.a_pos_pos <= COEF_ONE;
            coefs_reg.a_pos_vel <= COEF_ZERO;
            coefs_reg.a_vel_pos <= COEF_ZERO;
            coefs_reg.a_vel_vel <= COEF_ONE;
            coefs_reg.gain_pos  <= COEF_ZERO;
            coefs_reg.gain_vel  <= COEF_ZERO;
        end
        else if (wr_en)
        begin
            // Addresses past the last register are dropped.
            unique case (reg_idx)
                REG_A_POS_POS: coefs_reg.a_pos_pos <= wr_val;
                REG_A_POS_VEL: coefs_reg.a_pos_vel <= wr_val;
                REG_A_VEL_POS: coefs_reg.a_vel_pos <= wr_val;
                REG_A_VEL_VEL: coefs_reg.a_vel_vel <= wr_val;
                REG_GAIN_POS:  coefs_reg.gain_pos  <= wr_val;
                REG_GAIN_VEL:  coefs_reg.gain_vel  <= wr_val;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_A_POS_POS: rd_val = coefs_reg.a_pos_pos;
            REG_A_POS_VEL: rd_val = coefs_reg.a_pos_vel;
            REG_A_VEL_POS: rd_val = coefs_reg.a_vel_pos;
            REG_A_VEL_VEL: rd_val = coefs_reg.a_vel_vel;
            REG_GAIN_POS:  rd_val = coefs_reg.gain_pos;
            REG_GAIN_VEL:  rd_val = coefs_reg.gain_vel;
            default:       rd_val = COEF_ZERO;
        endcase
    end

    assign prdata = {{(PDATA_W-COEF_W){1'b0}}, rd_val};
    assign coefs  = coefs_reg;

endmodule

`default_nettype wire

FILE: rtl/core/fgk_row.sv
`timescale 1ns / 1ps
`default_nettype none

// One row of the filter: a_p * p + a_v * v + g * m, rounded from Q19.30
// to Q16.16 (halves upward) and clipped to 32 bits.
module fgk_row
    import fgk_pkg::*;
(
    input  wire coef_t  coef_p,
    input  wire coef_t  coef_v,
    input  wire coef_t  coef_m,
    input  wire state_t pos,
    input  wire state_t vel,
    input  wire state_t meas,
    output state_t      value,
    output logic        clipped
);

    localparam int PROD_W = COEF_W + STATE_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int FRAC   = 14;
    localparam int RND_W  = SUM_W - FRAC;

    localparam logic signed [SUM_W-1:0] HALF_LSB = SUM_W'(1) <<< (FRAC - 1);
    localparam logic signed [RND_W-1:0] VAL_MAX  = RND_W'(2147483647);
    localparam logic signed [RND_W-1:0] VAL_MIN  = -(RND_W'(2147483647)) - RND_W'(1);

    logic signed [PROD_W-1:0] prod_p;
    logic signed [PROD_W-1:0] prod_v;
    logic signed [PROD_W-1:0] prod_m;
    logic signed [SUM_W-1:0]  sum;
    logic signed [SUM_W-1:0]  sum_biased;
    logic signed [RND_W-1:0]  rounded;

    assign prod_p = PROD_W'(coef_p) * PROD_W'(pos);
    assign prod_v = PROD_W'(coef_v) * PROD_W'(vel);
    assign prod_m = PROD_W'(coef_m) * PROD_W'(meas);

    assign sum        = SUM_W'(prod_p) + SUM_W'(prod_v) + SUM_W'(prod_m);
    assign sum_biased = sum + HALF_LSB;
    // Dropping the low bits of a two's complement value is a floor.
    assign rounded    = sum_biased[SUM_W-1:FRAC];

    always_comb
    begin
        if (rounded > VAL_MAX)
        begin
            value   = state_t'(VAL_MAX[STATE_W-1:0]);
            clipped = 1'b1;
        end
        else if (rounded < VAL_MIN)
        begin
            value   = state_t'(VAL_MIN[STATE_W-1:0]);
            clipped = 1'b1;
        end
        else
        begin
            value   = rounded[STATE_W-1:0];
            clipped = 1'b0;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/encoder_fixed_gain_kalman_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Fixed-gain order-two Kalman filter, one position/velocity state per joint.
// Input words arrive on the s_axis channel: tuser is the kind (update with a
// measurement, or preset), tdata carries the joint and the Q16.16 value.
// Each word yields exactly one output word on m_axis: the joint, the new
// position and velocity, and in tuser a flag that a value was clipped.
// The six coefficients are written over the APB-style port; the user is to
// write them only while idle, as the block itself does not enforce it. A word
// passes from the input register to the output register that drives m_axis.
// Throughput is one word per cycle while the receiver does not stall, also when
// consecutive words name the same joint, since the joint state is read and
// rewritten between the two registers, at the edge that registers the result.
// When the receiver stalls, the output register holds its word and the input
// register still takes one more word; s_axis_tready falls only once both are
// full. Reset clears all joint states to zero, loads the coefficients with
// identity transition and zero gain, and empties both registers.
module encoder_fixed_gain_kalman_unit
    import fgk_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    // APB-style configuration port
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [PADDR_W-1:0]  paddr,
    input  wire logic [PDATA_W-1:0]  pwdata,
    output logic      [PDATA_W-1:0]  prdata,
    output logic                     pready,
    // Input words
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    input  wire logic [39:0]         s_axis_tdata,  // joint[2:0], measurement[34:3]
    input  wire logic                s_axis_tuser,  // opcode[0]
    // Output words
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    output logic      [71:0]         m_axis_tdata,  // joint_out[2:0], position[34:3],
                                                    // velocity[66:35]
    output logic                     m_axis_tuser   // saturated[0]
);

    coef_set_t coefs;

    logic   s1_valid_reg;
    logic   s1_valid_next;
    logic   s1_op_reg;
    joint_t s1_joint_reg;
    state_t s1_meas_reg;

    logic   out_valid_reg;
    logic   out_valid_next;
    joint_t out_joint_reg;
    state_t out_pos_reg;
    state_t out_vel_reg;
    logic   out_sat_reg;

    state_t pos_store_reg [JOINTS];
    state_t vel_store_reg [JOINTS];

    logic   out_free;
    logic   in_take;
    logic   advance;

    state_t old_pos;
    state_t old_vel;
    state_t upd_pos;
    state_t upd_vel;
    logic   clip_pos;
    logic   clip_vel;
    state_t new_pos;
    state_t new_vel;
    logic   new_sat;

    fgk_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .coefs   (coefs)
    );

    // Handshake
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = s1_valid_reg && out_free;
    assign s_axis_tready = !s1_valid_reg || out_free;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    assign s1_valid_next  = in_take || (s1_valid_reg && !out_free);
    assign out_valid_next = advance || (out_valid_reg && !m_axis_tready);

    // Compute
    assign old_pos = pos_store_reg[s1_joint_reg];
    assign old_vel = vel_store_reg[s1_joint_reg];

    fgk_row u_row_pos (
        .coef_p  (coefs.a_pos_pos),
        .coef_v  (coefs.a_pos_vel),
        .coef_m  (coefs.gain_pos),
        .pos     (old_pos),
        .vel     (old_vel),
        .meas    (s1_meas_reg),
        .value   (upd_pos),
        .clipped (clip_pos)
    );

    fgk_row u_row_vel (
        .coef_p  (coefs.a_vel_pos),
        .coef_v  (coefs.a_vel_vel),
        .coef_m  (coefs.gain_vel),
        .pos     (old_pos),
        .vel     (old_vel),
        .meas    (s1_meas_reg),
        .value   (upd_vel),
        .clipped (clip_vel)
    );

    always_comb
    begin
        if (s1_op_reg == OP_PRESET)
        begin
            new_pos = s1_meas_reg;
            new_vel = '0;
            new_sat = 1'b0;
        end
        else
        begin
            new_pos = upd_pos;
            new_vel = upd_vel;
            new_sat = clip_pos || clip_vel;
        end
    end

    // Control state and joint state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < JOINTS; i++)
            begin
                pos_store_reg[i] <= '0;
                vel_store_reg[i] <= '0;
            end
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                pos_store_reg[s1_joint_reg] <= new_pos;
                vel_store_reg[s1_joint_reg] <= new_vel;
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_op_reg    <= s_axis_tuser;
            s1_joint_reg <= s_axis_tdata[JOINT_W-1:0];
            s1_meas_reg  <= state_t'(s_axis_tdata[JOINT_W+STATE_W-1:JOINT_W]);
        end
        if (advance)
        begin
            out_joint_reg <= s1_joint_reg;
            out_pos_reg   <= new_pos;
            out_vel_reg   <= new_vel;
            out_sat_reg   <= new_sat;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0, out_vel_reg, out_pos_reg, out_joint_reg};
    assign m_axis_tuser  = out_sat_reg;

    // The input side only backs up when both registers hold a word.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (s1_valid_reg && out_valid_reg && !m_axis_tready))
        else $error("input stalled while a register was free");

    // A word that leaves the input register is always shown at the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("computed word lost");

    // The shown result and the stored joint state agree.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (pos_store_reg[out_joint_reg] == out_pos_reg
                     && vel_store_reg[out_joint_reg] == out_vel_reg))
        else $error("joint state and result disagree");

    // A preset clears the velocity and never reports clipping.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s1_op_reg == OP_PRESET) |=> (out_vel_reg == '0 && !out_sat_reg))
        else $error("preset left velocity or clip flag set");

endmodule

`default_nettype wire

FILE: tb/fgk_checker.sv
`timescale 1ns / 1ps

module fgk_checker
    import fgk_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    input  logic               pready,
    input  logic               s_axis_tvalid,
    input  logic               s_axis_tready,
    input  logic [39:0]        s_axis_tdata,
    input  logic               s_axis_tuser,
    input  logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    input  logic [71:0]        m_axis_tdata,
    input  logic               m_axis_tuser,
    output int                 fail_count,
    output int                 pending
);

    localparam int     FRAC_DROP = 14;
    localparam longint HALF_LSB  = longint'(1) <<< (FRAC_DROP - 1);
    localparam longint STATE_MAX = (longint'(1) <<< (STATE_W - 1)) - 1;
    localparam longint STATE_MIN = -(longint'(1) <<< (STATE_W - 1));

    typedef struct packed {
        joint_t joint;
        state_t position;
        state_t velocity;
        logic   saturated;
    } joint_estimate_t;

    coef_set_t       coefs;
    state_t          position_store [JOINTS];
    state_t          velocity_store [JOINTS];
    joint_estimate_t estimates_due [$];

    // Sum of Q19.30 products down to Q16.16, halves rounded upwards.
    function automatic longint round_q16(longint acc);
        return (acc + HALF_LSB) >>> FRAC_DROP;
    endfunction

    function automatic state_t clamp_state(longint value);
        if (value > STATE_MAX)
            return state_t'(STATE_MAX);
        if (value < STATE_MIN)
            return state_t'(STATE_MIN);
        return state_t'(value);
    endfunction

    function automatic joint_estimate_t advance_joint(logic op, joint_t j, state_t meas);
        joint_estimate_t est;
        longint          p0;
        longint          v0;
        longint          m;
        longint          pos_acc;
        longint          vel_acc;
        est.joint     = j;
        est.saturated = 1'b0;
        if (op == OP_PRESET)
        begin
            est.position = meas;
            est.velocity = '0;
        end
        else
        begin
            p0 = longint'(position_store[j]);
            v0 = longint'(velocity_store[j]);
            m  = longint'(meas);
            pos_acc = round_q16(longint'(coefs.a_pos_pos) * p0 + longint'(coefs.a_pos_vel) * v0
                                + longint'(coefs.gain_pos) * m);
            vel_acc = round_q16(longint'(coefs.a_vel_pos) * p0 + longint'(coefs.a_vel_vel) * v0
                                + longint'(coefs.gain_vel) * m);
            est.position  = clamp_state(pos_acc);
            est.velocity  = clamp_state(vel_acc);
            est.saturated = (longint'(est.position) != pos_acc)
                            || (longint'(est.velocity) != vel_acc);
        end
        position_store[j] = est.position;
        velocity_store[j] = est.velocity;
        return est;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        joint_estimate_t seen;
        joint_estimate_t want;
        if (!rst_n)
        begin
            coefs <= '{a_pos_pos: COEF_ONE, a_pos_vel: COEF_ZERO, a_vel_pos: COEF_ZERO,
                       a_vel_vel: COEF_ONE, gain_pos: COEF_ZERO, gain_vel: COEF_ZERO};
            for (int i = 0; i < JOINTS; i++)
            begin
                position_store[i] = '0;
                velocity_store[i] = '0;
            end
            estimates_due.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[PADDR_W-1:2])
                    REG_A_POS_POS: coefs.a_pos_pos <= pwdata[COEF_W-1:0];
                    REG_A_POS_VEL: coefs.a_pos_vel <= pwdata[COEF_W-1:0];
                    REG_A_VEL_POS: coefs.a_vel_pos <= pwdata[COEF_W-1:0];
                    REG_A_VEL_VEL: coefs.a_vel_vel <= pwdata[COEF_W-1:0];
                    REG_GAIN_POS:  coefs.gain_pos  <= pwdata[COEF_W-1:0];
                    REG_GAIN_VEL:  coefs.gain_vel  <= pwdata[COEF_W-1:0];
                    default: ;
                endcase
            end

            // The word leaving now always belongs to an earlier input, so it is
            // checked before the word arriving at this edge is predicted.
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen.joint     = m_axis_tdata[2:0];
                seen.position  = m_axis_tdata[34:3];
                seen.velocity  = m_axis_tdata[66:35];
                seen.saturated = m_axis_tuser;
                if (estimates_due.size() == 0)
                begin
                    $display("%0t: output word with nothing predicted: joint %0d pos %0d vel %0d",
                             $time, seen.joint, seen.position, seen.velocity);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = estimates_due.pop_front();
                    if (seen.joint !== want.joint)
                        $display("%0t: joint expected %0d actual %0d",
                                 $time, want.joint, seen.joint);
                    if (seen.position !== want.position)
                        $display("%0t: position expected %0d actual %0d",
                                 $time, want.position, seen.position);
                    if (seen.velocity !== want.velocity)
                        $display("%0t: velocity expected %0d actual %0d",
                                 $time, want.velocity, seen.velocity);
                    if (seen.saturated !== want.saturated)
                        $display("%0t: saturated expected %0b actual %0b",
                                 $time, want.saturated, seen.saturated);
                    if (seen !== want)
                        fail_count <= fail_count + 1;
                end
            end

            if (s_axis_tvalid && s_axis_tready)
                estimates_due = {estimates_due,
                                 advance_joint(s_axis_tuser, s_axis_tdata[2:0],
                                               s_axis_tdata[34:3])};

            pending <= estimates_due.size();
        end
    end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import fgk_pkg::*;

    localparam state_t MEAS_MAX = {1'b0, {(STATE_W-1){1'b1}}};
    localparam state_t MEAS_MIN = {1'b1, {(STATE_W-1){1'b0}}};
    localparam coef_t  COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
    localparam coef_t  COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};
    localparam logic [REG_IDX_W-1:0] REG_SPARE = REG_IDX_W'(REG_COUNT);

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [39:0]        s_axis_tdata;
    logic               s_axis_tuser;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [71:0]        m_axis_tdata;
    logic               m_axis_tuser;
    int                 fail_count;
    int                 pending;
    bit                 calm = 1'b0;
    int                 stall_left = 0;

    always #6 clk = ~clk;

    encoder_fixed_gain_kalman_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    fgk_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    // The receiver stalls in bursts at random until the calm stretch.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 7) == 0)
        begin
            stall_left    <= $urandom_range(0, 11);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    function automatic state_t pick_measurement();
        case ($urandom_range(0, 15))
            0:          return MEAS_MAX;
            1:          return MEAS_MIN;
            2:          return '0;
            3, 4, 5, 6: return state_t'($urandom);
            default:    return state_t'($urandom_range(0, 2097152)) - state_t'(1048576);
        endcase
    endfunction

    function automatic coef_t pick_coef();
        case ($urandom_range(0, 11))
            0:       return COEF_MAX;
            1:       return COEF_MIN;
            2:       return COEF_ZERO;
            3:       return COEF_ONE;
            4:       return coef_t'($urandom);
            default: return coef_t'($urandom_range(0, 32768)) - coef_t'(16384);
        endcase
    endfunction

    // Every task starts and ends at a falling edge.
    task automatic send_word(input logic op, input joint_t j, input state_t meas);
        int gap;
        gap = (!calm && $urandom_range(0, 5) == 0) ? $urandom_range(1, 12) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {5'b0, meas, j};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input coef_t value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= PDATA_W'(value);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic load_coefs(input coef_t app, input coef_t apv, input coef_t avp,
                              input coef_t avv, input coef_t gp, input coef_t gv);
        drain();
        apb_write(REG_A_POS_POS, app);
        apb_write(REG_A_POS_VEL, apv);
        apb_write(REG_A_VEL_POS, avp);
        apb_write(REG_A_VEL_VEL, avv);
        apb_write(REG_GAIN_POS, gp);
        apb_write(REG_GAIN_VEL, gv);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_UPDATE;
        m_axis_tready = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Coefficients as after reset: identity transition, no measurement gain.
        send_word(OP_PRESET, 3'd0, MEAS_MAX);
        send_word(OP_PRESET, 3'd7, MEAS_MIN);
        send_word(OP_UPDATE, 3'd0, '0);
        send_word(OP_UPDATE, 3'd7, MEAS_MAX);
        send_word(OP_PRESET, 3'd3, '1);
        send_word(OP_UPDATE, 3'd3, MEAS_MIN);
        drain();
        // A write beyond the last register must leave the coefficients alone.
        apb_write(REG_SPARE, COEF_MIN);
        send_word(OP_UPDATE, 3'd0, MEAS_MIN);

        // Largest coefficients drive both values into clipping.
        load_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
        send_word(OP_PRESET, 3'd1, MEAS_MAX);
        send_word(OP_UPDATE, 3'd1, MEAS_MAX);
        send_word(OP_UPDATE, 3'd1, MEAS_MIN);
        send_word(OP_PRESET, 3'd2, MEAS_MIN);
        send_word(OP_UPDATE, 3'd2, MEAS_MIN);

        load_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
        send_word(OP_UPDATE, 3'd0, MEAS_MAX);
        send_word(OP_UPDATE, 3'd7, MEAS_MIN);
        send_word(OP_UPDATE, 3'd0, '0);
        send_word(OP_PRESET, 3'd4, '0);
        send_word(OP_UPDATE, 3'd4, '1);

        for (int phase = 0; phase < 6; phase++)
        begin
            if (phase == 5)
            begin
                drain();
                calm = 1'b1;
            end
            load_coefs(pick_coef(), pick_coef(), pick_coef(), pick_coef(), pick_coef(),
                       pick_coef());
            for (int n = 0; n < 72; n++)
            begin
                // Once in the run the sender holds back until the filter has caught up.
                if (phase == 2 && n == 36)
                    drain();
                send_word(($urandom_range(0, 7) == 0) ? OP_PRESET : OP_UPDATE,
                          joint_t'($urandom_range(0, JOINTS - 1)), pick_measurement());
            end
        end

        drain();
        repeat (4) @(negedge clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
